// ===== rtl/rwcg_pkg.sv =====
// Shared constants and byte-mapping functions for the random word corpus generator.
package rwcg_pkg;

   // Splitmix64 constants
   localparam logic [63:0] SmGamma   = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] SmMul1    = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] SmMul2    = 64'h94D049BB133111EB;
   localparam logic [63:0] SeedReset = 64'h243F6A8885A308D3;

   // Corpus length after reset
   localparam logic [40:0] TotalReset = 41'd1073741824;

   // Rejection limits for the three byte uses
   localparam logic [7:0] LenLimit  = 8'd240;
   localparam logic [7:0] CharLimit = 8'd248;
   localparam logic [7:0] WsLimit   = 8'd252;

   // Register indexes on the configuration port
   localparam logic CsrSeed  = 1'b0;
   localparam logic CsrTotal = 1'b1;

   // Byte modulo 6 by reciprocal multiply (exact for all 8-bit values)
   function automatic logic [2:0] mod6(input logic [7:0] b);
      logic [15:0] prod;
      logic [5:0]  q;
      logic [7:0]  r;
      prod = 16'(b) * 16'd171;
      q    = prod[15:10];
      r    = b - 8'({2'b00, q} * 8'd6);
      return r[2:0];
   endfunction

   // Byte modulo 30 by reciprocal multiply (exact for all 8-bit values)
   function automatic logic [4:0] mod30(input logic [7:0] b);
      logic [15:0] prod;
      logic [3:0]  q;
      logic [7:0]  r;
      prod = 16'(b) * 16'd137;
      q    = prod[15:12];
      r    = b - 8'({4'b0000, q} * 8'd30);
      return r[4:0];
   endfunction

   // Byte modulo 62 by reciprocal multiply (exact for all 8-bit values)
   function automatic logic [5:0] mod62(input logic [7:0] b);
      logic [16:0] prod;
      logic [2:0]  q;
      logic [7:0]  r;
      prod = 17'(b) * 17'd265;
      q    = prod[16:14];
      r    = b - 8'({5'b00000, q} * 8'd62);
      return r[5:0];
   endfunction

   // Map a byte to the base62 alphabet: A-Z, a-z, 0-9
   function automatic logic [6:0] glyph(input logic [7:0] b);
      logic [5:0] r;
      logic [6:0] code;
      r = mod62(b);
      if (r < 6'd26) begin
         code = {1'b0, r} + 7'd65;
      end else if (r < 6'd52) begin
         code = {1'b0, r} + 7'd71;
      end else begin
         code = {1'b0, r} - 7'd4;
      end
      return code;
   endfunction

   // Map a byte to one of six whitespace characters
   function automatic logic [6:0] space_char(input logic [7:0] b);
      logic [6:0] code;
      unique case (mod6(b))
         3'd0:    code = 7'd32;
         3'd1:    code = 7'd10;
         3'd2:    code = 7'd13;
         3'd3:    code = 7'd9;
         3'd4:    code = 7'd11;
         3'd5:    code = 7'd12;
         default: code = 7'd32;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/rwcg_mixer.sv =====
// Splitmix64 generator built around one shared 32x32 multiplier.
module rwcg_mixer (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  logic [63:0] load_value,
   input  logic        start,
   output logic        done,
   output logic [63:0] rnd_word
);

   typedef enum logic {
      M_IDLE,
      M_MUL
   } mix_state_type;

   mix_state_type state_ff, state_in;
   logic [63:0] rng_ff, rng_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in;
   logic [63:0] rnd_ff, rnd_in;
   logic        done_ff, done_in;
   logic        second_ff, second_in;
   logic [1:0]  phase_ff, phase_in;

   logic [63:0] mul_const;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [63:0] acc_sum;
   logic [63:0] rng_next;

   // Pick constant half and operand half for the current phase
   always_comb begin
      mul_const = second_ff ? rwcg_pkg::SmMul2 : rwcg_pkg::SmMul1;
      op_a      = (phase_ff == 2'd1) ? x_ff[63:32] : x_ff[31:0];
      op_b      = (phase_ff == 2'd2) ? mul_const[63:32] : mul_const[31:0];
      acc_sum   = acc_ff + {prod_ff[31:0], 32'h0};
      rng_next  = rng_ff + rwcg_pkg::SmGamma;
   end

   // Sequence: advance state, then two 64-bit products in four phases each
   always_comb begin
      state_in  = state_ff;
      rng_in    = rng_ff;
      x_in      = x_ff;
      acc_in    = acc_ff;
      prod_in   = {32'h0, op_a} * {32'h0, op_b};
      rnd_in    = rnd_ff;
      done_in   = 1'b0;
      second_in = second_ff;
      phase_in  = phase_ff;
      unique case (state_ff)
         M_IDLE: begin
            if (load) begin
               rng_in = load_value;
            end else if (start) begin
               rng_in    = rng_next;
               x_in      = rng_next ^ (rng_next >> 30);
               second_in = 1'b0;
               phase_in  = 2'd0;
               state_in  = M_MUL;
            end
         end
         M_MUL: begin
            phase_in = phase_ff + 2'd1;
            unique case (phase_ff)
               2'd0: begin
               end
               2'd1: begin
                  acc_in = prod_ff;
               end
               2'd2: begin
                  acc_in = acc_sum;
               end
               2'd3: begin
                  acc_in = acc_sum;
                  if (!second_ff) begin
                     x_in      = acc_sum ^ (acc_sum >> 27);
                     second_in = 1'b1;
                  end else begin
                     rnd_in   = acc_sum ^ (acc_sum >> 31);
                     done_in  = 1'b1;
                     state_in = M_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
         default: state_in = M_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= M_IDLE;
         rng_ff    <= rwcg_pkg::SeedReset;
         done_ff   <= 1'b0;
         second_ff <= 1'b0;
         phase_ff  <= 2'd0;
      end else begin
         state_ff  <= state_in;
         rng_ff    <= rng_in;
         done_ff   <= done_in;
         second_ff <= second_in;
         phase_ff  <= phase_in;
      end
      x_ff    <= x_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      rnd_ff  <= rnd_in;
   end

   assign done     = done_ff;
   assign rnd_word = rnd_ff;

endmodule

// ===== rtl/random_word_corpus_generator.sv =====
// Top level of the random word corpus generator: request, response and register channels.
//
// Usage: each request beat (req_valid high, req_stall low) asks for one corpus
// character. req_restart = 1 reloads the generator from the seed and total
// registers before producing that character. Each request yields at most one
// response beat on rsp_char_code / rsp_last; once the corpus is finished a
// request without restart yields none. rsp_last marks the final character.
// Registers are written on the csr_ channel (index 0 seed, 1 total_bytes),
// which is always ready; new values take effect at the next restart.
// A request passes through the decide and draw states to the response
// register; each rejected byte costs one more draw, a word of drawn length
// first draws its length byte, and an empty 8-byte pool is refilled by the
// splitmix64 mixer, which runs two 64-bit products through one 32x32
// multiplier in four phases each.
// req_stall is high while a request is in work. The response sits in an
// output register; a stalled response holds, and a new request is accepted
// meanwhile, finishing only once the register frees up.
// Reset loads the register reset values and starts a fresh corpus.
module random_word_corpus_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_char_code,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_wdata
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECIDE,
      S_DRAW,
      S_MIX
   } state_type;

   typedef enum logic [1:0] {
      K_LEN,
      K_CHAR,
      K_FINAL,
      K_WS
   } kind_type;

   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   logic [63:0] seed_ff, seed_in;
   logic [40:0] total_ff, total_in;
   logic [63:0] pool_ff, pool_in;
   logic [3:0]  pool_left_ff, pool_left_in;
   logic [40:0] remain_ff, remain_in;
   logic [4:0]  word_left_ff, word_left_in;
   logic        in_word_ff, in_word_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  rsp_char_code_ff, rsp_char_code_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        mix_load;
   logic        mix_start;
   logic        mix_done;
   logic [63:0] mix_word;
   logic [7:0]  cur_byte;
   logic [7:0]  limit;
   logic        slot_busy;

   rwcg_mixer u_mixer (
      .clock      (clock),
      .reset      (reset),
      .load       (mix_load),
      .load_value (seed_ff),
      .start      (mix_start),
      .done       (mix_done),
      .rnd_word   (mix_word)
   );

   assign cur_byte  = pool_ff[7:0];
   assign slot_busy = rsp_valid_ff && rsp_stall;

   // Select the rejection limit for the current byte use
   always_comb begin
      unique case (kind_ff)
         K_LEN:   limit = rwcg_pkg::LenLimit;
         K_CHAR:  limit = rwcg_pkg::CharLimit;
         K_FINAL: limit = rwcg_pkg::CharLimit;
         K_WS:    limit = rwcg_pkg::WsLimit;
         default: limit = rwcg_pkg::CharLimit;
      endcase
   end

   // Take register writes
   always_comb begin
      seed_in  = seed_ff;
      total_in = total_ff;
      if (csr_valid) begin
         unique case (csr_index)
            rwcg_pkg::CsrSeed:  seed_in  = csr_wdata;
            rwcg_pkg::CsrTotal: total_in = csr_wdata[40:0];
            default: begin
            end
         endcase
      end
   end

   // Sequence one character: decide its kind, draw bytes, emit
   always_comb begin
      state_in         = state_ff;
      kind_in          = kind_ff;
      pool_in          = pool_ff;
      pool_left_in     = pool_left_ff;
      remain_in        = remain_ff;
      word_left_in     = word_left_ff;
      in_word_in       = in_word_ff;
      rsp_valid_in     = slot_busy;
      rsp_char_code_in = rsp_char_code_ff;
      rsp_last_in      = rsp_last_ff;
      mix_load         = 1'b0;
      mix_start        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_restart) begin
                  mix_load     = 1'b1;
                  pool_in      = 64'h0;
                  pool_left_in = 4'd0;
                  remain_in    = total_ff;
                  word_left_in = 5'd0;
                  in_word_in   = 1'b0;
               end
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (remain_ff == 41'd0) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_DRAW;
               if (!in_word_ff) begin
                  if (remain_ff == 41'd1) begin
                     kind_in = K_FINAL;
                  end else if (remain_ff <= 41'd31) begin
                     word_left_in = remain_ff[4:0] - 5'd1;
                     in_word_in   = 1'b1;
                     kind_in      = K_CHAR;
                  end else begin
                     kind_in = K_LEN;
                  end
               end else begin
                  kind_in = (word_left_ff != 5'd0) ? K_CHAR : K_WS;
               end
            end
         end
         S_DRAW: begin
            if (pool_left_ff == 4'd0) begin
               mix_start = 1'b1;
               state_in  = S_MIX;
            end else if (cur_byte >= limit || kind_ff == K_LEN || !slot_busy) begin
               // Consume the byte; reject, set word length, or emit
               pool_in      = {8'h0, pool_ff[63:8]};
               pool_left_in = pool_left_ff - 4'd1;
               if (cur_byte < limit) begin
                  unique case (kind_ff)
                     K_LEN: begin
                        word_left_in = rwcg_pkg::mod30(cur_byte) + 5'd1;
                        in_word_in   = 1'b1;
                        kind_in      = K_CHAR;
                     end
                     K_CHAR, K_FINAL: begin
                        rsp_char_code_in = rwcg_pkg::glyph(cur_byte);
                        if (kind_ff == K_CHAR) begin
                           word_left_in = word_left_ff - 5'd1;
                        end
                     end
                     K_WS: begin
                        rsp_char_code_in = rwcg_pkg::space_char(cur_byte);
                        in_word_in       = 1'b0;
                     end
                     default: begin
                     end
                  endcase
                  if (kind_ff != K_LEN) begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = (remain_ff == 41'd1);
                     remain_in    = remain_ff - 41'd1;
                     state_in     = S_IDLE;
                  end
               end
            end
         end
         S_MIX: begin
            if (mix_done) begin
               pool_in      = mix_word;
               pool_left_in = 4'd8;
               state_in     = S_DRAW;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state, registers and the response slot
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         kind_ff      <= K_LEN;
         seed_ff      <= rwcg_pkg::SeedReset;
         total_ff     <= rwcg_pkg::TotalReset;
         pool_ff      <= 64'h0;
         pool_left_ff <= 4'd0;
         remain_ff    <= rwcg_pkg::TotalReset;
         word_left_ff <= 5'd0;
         in_word_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         seed_ff      <= seed_in;
         total_ff     <= total_in;
         pool_ff      <= pool_in;
         pool_left_ff <= pool_left_in;
         remain_ff    <= remain_in;
         word_left_ff <= word_left_in;
         in_word_ff   <= in_word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_char_code_ff <= rsp_char_code_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_code_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the random word corpus generator.
module testbench;

   localparam int QuietCycles = 64;
   localparam int DrainLimit  = 200000;
   localparam int RandomItems = 850;

   typedef struct packed {
      logic [6:0] char_code;
      logic       last;
   } corpus_char_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [6:0]  rsp_char_code;
   logic        rsp_last;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic        csr_index   = rwcg_pkg::CsrSeed;
   logic [63:0] csr_wdata   = '0;

   // Generator mirror: register copies and running state
   logic [63:0] gen_seed;
   logic [40:0] gen_total;
   logic [63:0] gen_rng;
   logic [63:0] gen_pool;
   int          gen_pool_bytes;
   logic [40:0] gen_left;
   int          gen_word_left;
   bit          gen_in_word;

   corpus_char_type due_chars[$];
   bit              req_plan[$];
   corpus_char_type rsp_want;

   int errors        = 0;
   int chars_checked = 0;
   int requests_sent = 0;
   int settings_run  = 0;
   int holds_asked   = 0;
   int holds_done    = 0;
   int req_gap       = 0;
   int burst_left    = 0;
   int req_pick;
   int stall_left    = 0;
   int run_left      = 0;
   int rsp_pick;

   random_word_corpus_generator dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Start a fresh corpus from the register copies
   function automatic void reload_corpus();
      gen_rng        = gen_seed;
      gen_pool       = '0;
      gen_pool_bytes = 0;
      gen_left       = gen_total;
      gen_word_left  = 0;
      gen_in_word    = 1'b0;
   endfunction

   // Take pool bytes, refilling from splitmix64, until one is below the limit
   function automatic logic [7:0] draw_byte(input logic [7:0] limit);
      logic [7:0]  b;
      logic [63:0] z;
      do begin
         if (gen_pool_bytes == 0) begin
            gen_rng = gen_rng + rwcg_pkg::SmGamma;
            z = gen_rng;
            z = (z ^ (z >> 30)) * rwcg_pkg::SmMul1;
            z = (z ^ (z >> 27)) * rwcg_pkg::SmMul2;
            gen_pool = z ^ (z >> 31);
            gen_pool_bytes = 8;
         end
         b = gen_pool[7:0];
         gen_pool = gen_pool >> 8;
         gen_pool_bytes--;
      end while (b >= limit);
      return b;
   endfunction

   // Letters first, then digits
   function automatic logic [6:0] alnum_code(input logic [7:0] b);
      logic [7:0] r;
      r = b % 8'd62;
      if (r < 8'd26) return 7'("A" + r);
      if (r < 8'd52) return 7'("a" + (r - 8'd26));
      return 7'("0" + (r - 8'd52));
   endfunction

   function automatic logic [6:0] blank_code(input logic [7:0] b);
      case (b % 8'd6)
         8'd0:    return 7'd32;   // space
         8'd1:    return 7'd10;   // line feed
         8'd2:    return 7'd13;   // carriage return
         8'd3:    return 7'd9;    // tab
         8'd4:    return 7'd11;   // vertical tab
         default: return 7'd12;   // form feed
      endcase
   endfunction

   // Work out the character one request yields, if any
   task automatic advance_corpus(input logic restart);
      corpus_char_type c;
      if (restart) reload_corpus();
      if (gen_left == '0) return;
      // A lone final byte is one alphanumeric character
      if (!gen_in_word && gen_left == 41'd1) begin
         c.char_code = alnum_code(draw_byte(rwcg_pkg::CharLimit));
         c.last = 1'b1;
         gen_left = '0;
         due_chars.push_back(c);
         return;
      end
      // Near the end the last word fills the corpus exactly
      if (!gen_in_word) begin
         if (gen_left <= 41'd31) gen_word_left = int'(gen_left) - 1;
         else gen_word_left = int'(draw_byte(rwcg_pkg::LenLimit) % 8'd30) + 1;
         gen_in_word = 1'b1;
      end
      if (gen_word_left > 0) begin
         c.char_code = alnum_code(draw_byte(rwcg_pkg::CharLimit));
         gen_word_left--;
      end else begin
         c.char_code = blank_code(draw_byte(rwcg_pkg::WsLimit));
         gen_in_word = 1'b0;
      end
      gen_left = gen_left - 41'd1;
      c.last = (gen_left == '0);
      due_chars.push_back(c);
   endtask

   // Register write; only called while the block is idle
   task automatic write_csr(input logic idx, input logic [63:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == rwcg_pkg::CsrSeed) gen_seed = data;
      else gen_total = data[40:0];
   endtask

   // Queue one corpus run: a restart, then plain requests with rare restarts
   task automatic queue_corpus(input longint n, input int restart_odds);
      req_plan.push_back(1'b1);
      for (longint i = 1; i < n; i++)
         req_plan.push_back(restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
      settings_run++;
   endtask

   // Wait for every queued request and character, then let the block go quiet
   task automatic settle();
      int waited;
      waited = 0;
      while ((req_plan.size() != 0 || req_valid || due_chars.size() != 0)
             && waited < DrainLimit) begin
         @(negedge clock);
         waited++;
      end
      repeat (QuietCycles) @(negedge clock);
   endtask

   // Request driver: predict on each accepted beat, then offer the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            advance_corpus(req_restart);
            requests_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap = req_gap - 1;
               req_valid <= 1'b0;
            end else if (req_plan.size() > 0) begin
               req_valid <= 1'b1;
               req_restart <= req_plan.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
                  req_gap = 0;
               end else begin
                  req_pick = $urandom_range(0, 99);
                  if (req_pick < 5) begin
                     burst_left = $urandom_range(10, 40);
                     req_gap = 0;
                  end else if (req_pick < 45) begin
                     req_gap = 0;
                  end else if (req_pick < 85) begin
                     req_gap = $urandom_range(1, 3);
                  end else if (req_pick < 97) begin
                     req_gap = $urandom_range(4, 12);
                  end else begin
                     req_gap = $urandom_range(20, 80);
                  end
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each beat and pick the next stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_chars.size() == 0) begin
               $error("unexpected character beat: rsp_char_code %0d, rsp_last %0d",
                      rsp_char_code, rsp_last);
               errors++;
            end else begin
               rsp_want = due_chars.pop_front();
               if (rsp_char_code !== rsp_want.char_code) begin
                  $error("rsp_char_code: expected %0d, got %0d",
                         rsp_want.char_code, rsp_char_code);
                  errors++;
               end
               if (rsp_last !== rsp_want.last) begin
                  $error("rsp_last: expected %0d, got %0d", rsp_want.last, rsp_last);
                  errors++;
               end
               chars_checked++;
            end
         end
         // Long hold so the block backs up and stalls its requests
         if (holds_done < holds_asked) begin
            holds_done++;
            stall_left = $urandom_range(200, 400);
            run_left = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
            rsp_stall <= 1'b0;
         end else begin
            rsp_pick = $urandom_range(0, 99);
            if (rsp_pick < 40) begin
               run_left = $urandom_range(5, 40);
               rsp_stall <= 1'b0;
            end else if (rsp_pick < 90) begin
               stall_left = $urandom_range(0, 2);
               rsp_stall <= 1'b1;
            end else begin
               stall_left = $urandom_range(9, 59);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   initial begin
      longint n;
      longint counted;
      longint planned;
      int     pick;
      gen_seed  = rwcg_pkg::SeedReset;
      gen_total = rwcg_pkg::TotalReset;
      reload_corpus();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Corpus from the reset register values
      repeat (4) req_plan.push_back(1'b0);
      settle();
      // One-character corpus, then requests after it has finished
      write_csr(rwcg_pkg::CsrSeed, '0);
      write_csr(rwcg_pkg::CsrTotal, 64'd1);
      queue_corpus(3, 0);
      settle();
      // Two characters: a one-letter word and its whitespace
      write_csr(rwcg_pkg::CsrTotal, 64'd2);
      queue_corpus(2, 0);
      settle();
      // Empty corpus
      write_csr(rwcg_pkg::CsrSeed, '1);
      write_csr(rwcg_pkg::CsrTotal, '0);
      queue_corpus(2, 0);
      settle();
      // Corpus of 2^40 characters, opening characters only
      write_csr(rwcg_pkg::CsrTotal, 64'h100_0000_0000);
      queue_corpus(6, 0);
      settle();
      // Short corpus with junk above the total field; the last word fills it
      write_csr(rwcg_pkg::CsrSeed, {$urandom, $urandom});
      write_csr(rwcg_pkg::CsrTotal, {23'h7FFFFF, 41'd7});
      queue_corpus(8, 0);
      settle();

      // Back-pressure run: long output hold while requests keep coming
      write_csr(rwcg_pkg::CsrSeed, {$urandom, $urandom});
      write_csr(rwcg_pkg::CsrTotal, 64'd300);
      queue_corpus(300, 0);
      holds_asked++;
      settle();
      planned = 300;

      // Random corpora of mostly small sizes
      while (planned < RandomItems) begin
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) write_csr(rwcg_pkg::CsrSeed, '0);
            else if (pick == 1) write_csr(rwcg_pkg::CsrSeed, '1);
            else write_csr(rwcg_pkg::CsrSeed, {$urandom, $urandom});
         end
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               n = $urandom_range(1, 40);
            end else if (pick < 85) begin
               n = $urandom_range(41, 300);
            end else if (pick < 93) begin
               n = $urandom_range(301, 5000);
            end else begin
               case ($urandom_range(0, 3))
                  0:       n = 0;
                  1:       n = 64'h1FF_FFFF_FFFF;
                  2:       n = 64'h100_0000_0000;
                  default: n = {9'($urandom), 32'($urandom)};
               endcase
            end
            write_csr(rwcg_pkg::CsrTotal, {23'($urandom), n[40:0]});
         end
         n = longint'(gen_total);
         if (n <= 300) n = n + $urandom_range(0, 3);
         else n = $urandom_range(20, 120);
         if (n < 1) n = 1;
         counted = (n > longint'(gen_total)) ? longint'(gen_total) : n;
         queue_corpus(n, 40);
         if ($urandom_range(0, 7) == 0) holds_asked++;
         planned += counted;
         settle();
      end

      if (due_chars.size() != 0) begin
         $error("%0d expected characters never arrived", due_chars.size());
         errors++;
      end
      $display("Covered %0d requests over %0d corpus runs,", requests_sent, settings_run);
      $display("with %0d characters checked and %0d long holds.", chars_checked, holds_done);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rwcg_pkg.sv
rtl/rwcg_mixer.sv
rtl/random_word_corpus_generator.sv
sim/testbench.sv
